// ----- hdl/work_stealing_task_queue_top_assert.svh -----
// assertion macros for the work stealing task queue
`ifndef WORK_STEALING_TASK_QUEUE_TOP_ASSERT_SVH
`define WORK_STEALING_TASK_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define WSTQ_ASSERT_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wstq assertion failed");

`define WSTQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wstq implication failed");

`define WSTQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wstq next-cycle check failed");

`else

`define WSTQ_ASSERT_ALWAYS(name, clk, rstn, prop)
`define WSTQ_ASSERT_IMP(name, clk, rstn, ante, cons)
`define WSTQ_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/wstq_pkg.sv -----
package wstq_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned KEEP_W     = 6;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned IDENT_W    = 32;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned ORIGIN_W   = 8;
  localparam int unsigned STEALS_W   = 8;
  localparam int unsigned SHARE_W    = 7;
  localparam int unsigned PLEN_W     = 16;
  localparam int unsigned CPU_W      = 7;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_ASSIGN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRANSFER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEAL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd4;

  localparam logic [KIND_W-1:0] REPLY_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] REPLY_REJECTED = 3'd1;
  localparam logic [KIND_W-1:0] REPLY_STOLEN   = 3'd2;
  localparam logic [KIND_W-1:0] REPLY_REFUSED  = 3'd3;
  localparam logic [KIND_W-1:0] REPLY_NONE     = 3'd4;
  localparam logic [KIND_W-1:0] REPLY_TAKEN    = 3'd5;
  localparam logic [KIND_W-1:0] REPLY_EMPTY    = 3'd6;
  localparam logic [KIND_W-1:0] REPLY_CHECK    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL_LIMIT = 2'd2;

  localparam logic [CAP_W-1:0]   CAPACITY_RST    = 7'd16;
  localparam logic [KEEP_W-1:0]  MIN_KEEP_RST    = 6'd2;
  localparam logic [LIMIT_W-1:0] STEAL_LIMIT_RST = 8'd3;

  localparam logic [CPU_W-1:0]    CPU_BUSY  = 7'd80;
  localparam logic [STEALS_W-1:0] STEAL_SAT = 8'd255;
  localparam logic [RUN_W-1:0]    MAX_RUN   = 6'd32;

  typedef struct packed {
    logic [IDENT_W-1:0]  ident;
    logic [DUR_W-1:0]    duration;
    logic [ORIGIN_W-1:0] origin;
    logic [STEALS_W-1:0] steals;
  } task_t;

  typedef struct packed {
    logic              latch;
    logic              push;
    logic              load_run;
    logic              load_one;
    logic              rd_en;
    logic              pop;
    logic              emit;
    logic              emit_task;
    logic              steal_inc;
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              should;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             store_full;
    logic             cap_reached;
    logic             steal_refused;
    logic             steal_zero;
    logic             empty;
    logic             check_ok;
    logic             run_last;
    logic             out_free;
  } dp_status_t;

endpackage

// ----- hdl/wstq_ctrl.sv -----
`include "work_stealing_task_queue_top_assert.svh"

module wstq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wstq_pkg::dp_status_t status_i,
  output wstq_pkg::ctrl_cmd_t  ctrl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       run_steal_q, run_steal_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    logic reject;
    reject      = 1'b0;
    ctrl_o      = '0;
    state_d     = state_q;
    run_steal_d = run_steal_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (status_i.cmd)
          wstq_pkg::CMD_ASSIGN, wstq_pkg::CMD_TRANSFER: begin
            reject = status_i.store_full ||
                     (status_i.cmd == wstq_pkg::CMD_ASSIGN && status_i.cap_reached);
            if (status_i.out_free) begin
              ctrl_o.push = !reject;
              ctrl_o.emit = 1'b1;
              ctrl_o.kind = reject ? wstq_pkg::REPLY_REJECTED : wstq_pkg::REPLY_ACCEPTED;
              ctrl_o.last = 1'b1;
              state_d     = S_IDLE;
            end
          end
          wstq_pkg::CMD_STEAL: begin
            priority if (status_i.steal_refused) begin
              if (status_i.out_free) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.kind = wstq_pkg::REPLY_REFUSED;
                ctrl_o.last = 1'b1;
                state_d     = S_IDLE;
              end
            end else if (status_i.steal_zero) begin
              if (status_i.out_free) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.kind = wstq_pkg::REPLY_NONE;
                ctrl_o.last = 1'b1;
                state_d     = S_IDLE;
              end
            end else begin
              ctrl_o.load_run = 1'b1;
              run_steal_d     = 1'b1;
              state_d         = S_READ;
            end
          end
          wstq_pkg::CMD_TAKE: begin
            if (status_i.empty) begin
              if (status_i.out_free) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.kind = wstq_pkg::REPLY_EMPTY;
                ctrl_o.last = 1'b1;
                state_d     = S_IDLE;
              end
            end else begin
              ctrl_o.load_one = 1'b1;
              run_steal_d     = 1'b0;
              state_d         = S_READ;
            end
          end
          wstq_pkg::CMD_CHECK: begin
            if (status_i.out_free) begin
              ctrl_o.emit   = 1'b1;
              ctrl_o.kind   = wstq_pkg::REPLY_CHECK;
              ctrl_o.last   = 1'b1;
              ctrl_o.should = status_i.check_ok;
              state_d       = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          ctrl_o.pop       = 1'b1;
          ctrl_o.emit      = 1'b1;
          ctrl_o.emit_task = 1'b1;
          ctrl_o.steal_inc = run_steal_q;
          ctrl_o.kind      = run_steal_q ? wstq_pkg::REPLY_STOLEN : wstq_pkg::REPLY_TAKEN;
          ctrl_o.last      = status_i.run_last;
          state_d          = status_i.run_last ? S_IDLE : S_READ;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_steal_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_steal_q <= run_steal_d;
    end
  end

  `WSTQ_ASSERT_NXT(a_accept_to_decide, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DECIDE)
  `WSTQ_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, state_q == S_EMIT && status_i.out_free && status_i.run_last, state_q == S_IDLE)
  `WSTQ_ASSERT_IMP(a_emit_after_read, clk_i, rst_ni, state_q == S_EMIT, $past(state_q) == S_READ || $past(state_q) == S_EMIT)

endmodule

// ----- hdl/wstq_dp.sv -----
`include "work_stealing_task_queue_top_assert.svh"

module wstq_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wstq_pkg::ctrl_cmd_t                 ctl_i,
  output wstq_pkg::dp_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic [wstq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wstq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [wstq_pkg::CMD_W-1:0]          command_i,
  input  logic [wstq_pkg::IDENT_W-1:0]        task_ident_i,
  input  logic [wstq_pkg::DUR_W-1:0]          task_duration_ms_i,
  input  logic [wstq_pkg::ORIGIN_W-1:0]       task_origin_i,
  input  logic [wstq_pkg::STEALS_W-1:0]       task_steals_i,
  input  logic [wstq_pkg::SHARE_W-1:0]        share_limit_i,
  input  logic [wstq_pkg::PLEN_W-1:0]         peer_queue_length_i,
  input  logic [wstq_pkg::CPU_W-1:0]          peer_cpu_percent_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wstq_pkg::KIND_W-1:0]         reply_kind_o,
  output logic [wstq_pkg::IDENT_W-1:0]        out_ident_o,
  output logic [wstq_pkg::DUR_W-1:0]          out_duration_ms_o,
  output logic [wstq_pkg::ORIGIN_W-1:0]       out_origin_o,
  output logic [wstq_pkg::STEALS_W-1:0]       out_steals_o,
  output logic                                last_of_run_o,
  output logic [wstq_pkg::FILL_W-1:0]         fill_level_o,
  output logic                                should_steal_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = CW + wstq_pkg::STEALS_W;
  localparam int unsigned PRODW = wstq_pkg::LIMIT_W + CW;
  localparam int unsigned CMPW  = ((CW > wstq_pkg::PLEN_W) ? CW : wstq_pkg::PLEN_W) + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  // latched item
  logic [wstq_pkg::CMD_W-1:0]    cmd_q;
  wstq_pkg::task_t               task_q;
  logic [wstq_pkg::SHARE_W-1:0]  share_q;
  logic [wstq_pkg::PLEN_W-1:0]   plen_q;
  logic [wstq_pkg::CPU_W-1:0]    cpu_q;

  // configuration
  logic [wstq_pkg::CAP_W-1:0]    cap_q;
  logic [wstq_pkg::KEEP_W-1:0]   keep_q;
  logic [wstq_pkg::LIMIT_W-1:0]  limit_q;

  // queue state
  wstq_pkg::task_t               mem [QUEUE_DEPTH];
  wstq_pkg::task_t               rd_q;
  logic [AW-1:0]                 head_q, tail_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [SW-1:0]                 sum_q;
  logic [wstq_pkg::RUN_W-1:0]    run_q;

  // result register
  logic                          out_valid_q;
  logic [wstq_pkg::KIND_W-1:0]   out_kind_q;
  wstq_pkg::task_t               out_task_q;
  logic                          out_last_q;
  logic [wstq_pkg::FILL_W-1:0]   out_fill_q;
  logic                          out_should_q;

  logic [CMPW-1:0]               count_x, cap_x, keep_x, plen_x, share_x;
  logic [CMPW-1:0]               half_x, nmin_x;
  logic [wstq_pkg::RUN_W-1:0]    n_steal;
  logic [PRODW-1:0]              prod;
  wstq_pkg::task_t               emit_task;

  assign count_x = CMPW'(count_q);
  assign cap_x   = CMPW'(cap_q);
  assign keep_x  = CMPW'(keep_q);
  assign plen_x  = CMPW'(plen_q);
  assign share_x = CMPW'(share_q);

  // share half the excess, bounded by the request and the run length
  always_comb begin
    half_x = (count_x - keep_x) >> 1;
    nmin_x = (half_x < share_x) ? half_x : share_x;
    if (nmin_x > CMPW'(wstq_pkg::MAX_RUN)) begin
      nmin_x = CMPW'(wstq_pkg::MAX_RUN);
    end
    n_steal = nmin_x[wstq_pkg::RUN_W-1:0];
  end

  assign prod = PRODW'(limit_q) * PRODW'(count_q);

  assign status_o.cmd           = cmd_q;
  assign status_o.store_full    = (count_q >= DEPTH_CNT);
  assign status_o.cap_reached   = (count_x >= cap_x);
  assign status_o.steal_refused = (count_x <= keep_x);
  assign status_o.steal_zero    = (n_steal == '0);
  assign status_o.empty         = (count_q == '0);
  assign status_o.check_ok      = (plen_x > keep_x) && (count_x < cap_x) &&
                                  (plen_x > count_x + CMPW'(1)) &&
                                  (cpu_q < wstq_pkg::CPU_BUSY) &&
                                  ((count_q == '0) || (PRODW'(sum_q) < prod));
  assign status_o.run_last      = (run_q == wstq_pkg::RUN_W'(1));
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (ctl_i.push) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    emit_task = rd_q;
    if (ctl_i.steal_inc && rd_q.steals != wstq_pkg::STEAL_SAT) begin
      emit_task.steals = rd_q.steals + wstq_pkg::STEALS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q           <= command_i;
      task_q.ident    <= task_ident_i;
      task_q.duration <= task_duration_ms_i;
      task_q.origin   <= task_origin_i;
      task_q.steals   <= task_steals_i;
      share_q         <= share_limit_i;
      plen_q          <= peer_queue_length_i;
      cpu_q           <= peer_cpu_percent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= wstq_pkg::CAPACITY_RST;
      keep_q  <= wstq_pkg::MIN_KEEP_RST;
      limit_q <= wstq_pkg::STEAL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wstq_pkg::CFG_CAPACITY:    cap_q   <= cfg_wdata_i[wstq_pkg::CAP_W-1:0];
        wstq_pkg::CFG_MIN_KEEP:    keep_q  <= cfg_wdata_i[wstq_pkg::KEEP_W-1:0];
        wstq_pkg::CFG_STEAL_LIMIT: limit_q <= cfg_wdata_i[wstq_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= task_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      run_q   <= '0;
    end else begin
      count_q <= count_d;
      if (ctl_i.push) begin
        tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
        sum_q  <= sum_q + SW'(task_q.steals);
      end else if (ctl_i.pop) begin
        head_q <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
        sum_q  <= sum_q - SW'(rd_q.steals);
      end
      priority if (ctl_i.load_run) begin
        run_q <= n_steal;
      end else if (ctl_i.load_one) begin
        run_q <= wstq_pkg::RUN_W'(1);
      end else if (ctl_i.pop) begin
        run_q <= run_q - wstq_pkg::RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_kind_q   <= ctl_i.kind;
      out_last_q   <= ctl_i.last;
      out_should_q <= ctl_i.should;
      out_fill_q   <= wstq_pkg::FILL_W'(count_d);
      out_task_q   <= ctl_i.emit_task ? emit_task : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign reply_kind_o      = out_kind_q;
  assign out_ident_o       = out_task_q.ident;
  assign out_duration_ms_o = out_task_q.duration;
  assign out_origin_o      = out_task_q.origin;
  assign out_steals_o      = out_task_q.steals;
  assign last_of_run_o     = out_last_q;
  assign fill_level_o      = out_fill_q;
  assign should_steal_o    = out_should_q;

  `WSTQ_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= DEPTH_CNT)
  `WSTQ_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, ctl_i.pop, count_q != '0)
  `WSTQ_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, ctl_i.push, count_q < DEPTH_CNT)
  `WSTQ_ASSERT_IMP(a_empty_consistent, clk_i, rst_ni, count_q == '0, sum_q == '0 && head_q == tail_q)

endmodule

// ----- hdl/work_stealing_task_queue_top.sv -----
// work stealing task queue
// input channel: in_valid_i / in_stall_o with command_i and the task and peer fields;
// an item is taken when in_valid_i is high and in_stall_o is low. one item at a time.
// output channel: out_valid_o / out_stall_i; one result per item (none for an unused
// command); a granted steal gives a run of stolen tasks, last_of_run_o on the final one.
// config: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_wdata_i, always ready;
// the user must write only while the queue is idle; the block does not enforce it.
// enqueue, refusal, empty and check replies are loaded into the output register from the
// decide state. take and steal read the task store (one registered read port) in the read
// state and load each task in the emit state, alternating between the two, so a task is
// read only after the previous one is emitted. the next item is taken in the cycle after
// the last result is loaded.
// a stalled result holds the output register; the sequencer waits until it is taken.
// reset empties the queue and loads capacity 16, min keep 2, steal limit 3; the task
// store itself is not cleared.
module work_stealing_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wstq_pkg::CMD_W-1:0]          command_i,
  input  logic [wstq_pkg::IDENT_W-1:0]        task_ident_i,
  input  logic [wstq_pkg::DUR_W-1:0]          task_duration_ms_i,
  input  logic [wstq_pkg::ORIGIN_W-1:0]       task_origin_i,
  input  logic [wstq_pkg::STEALS_W-1:0]       task_steals_i,
  input  logic [wstq_pkg::SHARE_W-1:0]        share_limit_i,
  input  logic [wstq_pkg::PLEN_W-1:0]         peer_queue_length_i,
  input  logic [wstq_pkg::CPU_W-1:0]          peer_cpu_percent_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wstq_pkg::KIND_W-1:0]         reply_kind_o,
  output logic [wstq_pkg::IDENT_W-1:0]        out_ident_o,
  output logic [wstq_pkg::DUR_W-1:0]          out_duration_ms_o,
  output logic [wstq_pkg::ORIGIN_W-1:0]       out_origin_o,
  output logic [wstq_pkg::STEALS_W-1:0]       out_steals_o,
  output logic                                last_of_run_o,
  output logic [wstq_pkg::FILL_W-1:0]         fill_level_o,
  output logic                                should_steal_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wstq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wstq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  wstq_pkg::ctrl_cmd_t  ctl;
  wstq_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  wstq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctl)
  );

  wstq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .status_o            (status),
    .cfg_valid_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .command_i           (command_i),
    .task_ident_i        (task_ident_i),
    .task_duration_ms_i  (task_duration_ms_i),
    .task_origin_i       (task_origin_i),
    .task_steals_i       (task_steals_i),
    .share_limit_i       (share_limit_i),
    .peer_queue_length_i (peer_queue_length_i),
    .peer_cpu_percent_i  (peer_cpu_percent_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .reply_kind_o        (reply_kind_o),
    .out_ident_o         (out_ident_o),
    .out_duration_ms_o   (out_duration_ms_o),
    .out_origin_o        (out_origin_o),
    .out_steals_o        (out_steals_o),
    .last_of_run_o       (last_of_run_o),
    .fill_level_o        (fill_level_o),
    .should_steal_o      (should_steal_o)
  );

endmodule
